FILE: rtl/fbfl_pkg.sv
`default_nettype none

package fbfl_pkg;

  localparam int MAX_BLOCKS_DEF = 256;

  localparam int CMD_W   = 1;
  localparam int REL_W   = 8;
  localparam int BIDX_W  = 8;
  localparam int BYTES_W = 24;
  localparam int CNT_W   = 9;
  localparam int SIZE_W  = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd64;
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 9'd256;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic             load;
    logic             ok;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/fbfl_req_if.sv
`default_nettype none

interface fbfl_req_if;
  logic                       valid;
  logic                       ready;
  logic [fbfl_pkg::CMD_W-1:0] cmd;
  logic [fbfl_pkg::REL_W-1:0] release_index;

  modport source (output valid, output cmd, output release_index, input ready);
  modport sink (input valid, input cmd, input release_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/fbfl_rsp_if.sv
`default_nettype none

interface fbfl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [fbfl_pkg::BIDX_W-1:0]  block_index;
  logic [fbfl_pkg::BYTES_W-1:0] block_offset;
  logic [fbfl_pkg::BYTES_W-1:0] used_bytes;
  logic [fbfl_pkg::CNT_W-1:0]   allocations;

  modport source (output valid, output ok, output block_index, output block_offset,
                  output used_bytes, output allocations, input ready);
  modport sink (input valid, input ok, input block_index, input block_offset,
                input used_bytes, input allocations, output ready);
endinterface

`default_nettype wire

FILE: rtl/fixed_block_free_list_allocator.sv
// Channel  Dir  Beat fields
// -------  ---  ----------------------------------------------------------
// req      in   cmd, release_index
// rsp      out  ok, block_index, block_offset, used_bytes, allocations
// cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// Each request passes through the TAKE and CALC states: the free-list head's
// link is read from the registered-read link memory before the next head is
// known. After reset and after each write to block_count, the link memory is
// rebuilt over all MAX_BLOCKS entries, during which req.ready stays low.
// A finished beat waits in the output register; one further request is taken
// meanwhile and then holds until the output register frees.
`default_nettype none

module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data,
  fbfl_req_if.sink                             req,
  fbfl_rsp_if.source                           rsp
);

  localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W  = $clog2(MAX_BLOCKS);

  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [LINK_W-1:0]             mem_wdata;
  logic                          mem_re;
  logic [IDX_W-1:0]              mem_raddr;
  logic [LINK_W-1:0]             mem_rdata;
  logic                          out_free;
  fbfl_pkg::result_t             result;
  logic [fbfl_pkg::SIZE_W-1:0]   block_size;

  fbfl_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .result    (result),
    .block_size(block_size)
  );

  fbfl_link_mem #(
    .DEPTH (MAX_BLOCKS),
    .DATA_W(LINK_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  fbfl_out u_out (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .block_size(block_size),
    .out_free  (out_free),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/fbfl_link_mem.sv
`default_nettype none

module fbfl_link_mem #(
  parameter int DEPTH  = fbfl_pkg::MAX_BLOCKS_DEF,
  parameter int DATA_W = 9
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fbfl_ctrl.sv
`default_nettype none

module fbfl_ctrl #(
  parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,
  localparam int LINK_W = $clog2(MAX_BLOCKS + 1),
  localparam int IDX_W  = $clog2(MAX_BLOCKS)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_data,
  fbfl_req_if.sink                                 req,
  output logic                                     mem_we,
  output logic      [IDX_W-1:0]                    mem_waddr,
  output logic      [LINK_W-1:0]                   mem_wdata,
  output logic                                     mem_re,
  output logic      [IDX_W-1:0]                    mem_raddr,
  input  wire logic [LINK_W-1:0]                   mem_rdata,
  input  wire logic                                out_free,
  output fbfl_pkg::result_t                        result,
  output logic      [fbfl_pkg::SIZE_W-1:0]         block_size
);

  localparam int CNT_W = fbfl_pkg::CNT_W;
  localparam int CMP_W = (LINK_W > CNT_W) ? LINK_W : CNT_W;
  localparam logic [CMP_W-1:0]  MAX_C     = CMP_W'(MAX_BLOCKS);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);
  localparam logic [IDX_W-1:0]  LAST_ADDR = IDX_W'(MAX_BLOCKS - 1);

  localparam logic S_TAKE = 1'b0;
  localparam logic S_CALC = 1'b1;

  logic              state;
  logic [CNT_W-1:0]  block_count;
  logic [LINK_W-1:0] head;
  logic [CNT_W-1:0]  count;
  logic              sweep_on;
  logic [IDX_W-1:0]  sweep_addr;
  logic              op_ok;
  logic              op_alloc;
  logic [CNT_W-1:0]  op_idx;

  logic [CMP_W-1:0]  bc_ext;
  logic [CMP_W-1:0]  eff;
  logic [CMP_W-1:0]  sweep_nxt;
  logic              alloc_ok;
  logic              rel_ok;
  logic              accept;
  logic              is_alloc;
  logic              load;
  logic              count_write;

  assign bc_ext   = CMP_W'(block_count);
  assign eff      = (block_count == '0) ? CMP_W'(1) : ((bc_ext > MAX_C) ? MAX_C : bc_ext);
  assign alloc_ok = CMP_W'(head) < eff;
  assign rel_ok   = CMP_W'(req.release_index) < eff;
  assign is_alloc = (req.cmd == fbfl_pkg::CMD_ALLOC);

  assign req.ready   = (state == S_TAKE) && !sweep_on;
  assign accept      = req.valid && req.ready;
  assign load        = (state == S_CALC) && out_free;
  assign count_write = cfg_we && (cfg_index == fbfl_pkg::REG_BLOCK_COUNT);

  assign sweep_nxt = CMP_W'(sweep_addr) + CMP_W'(1);

  always_comb begin
    if (sweep_on) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = (sweep_nxt < eff) ? LINK_W'(sweep_nxt) : NULL_LINK;
    end else begin
      mem_we    = accept && !is_alloc && rel_ok;
      mem_waddr = IDX_W'(req.release_index);
      mem_wdata = head;
    end
  end

  assign mem_re    = accept && is_alloc && alloc_ok;
  assign mem_raddr = IDX_W'(head);

  assign result.load  = load;
  assign result.ok    = op_ok;
  assign result.idx   = op_idx;
  assign result.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_TAKE;
      block_size  <= fbfl_pkg::BLOCK_SIZE_RST;
      block_count <= fbfl_pkg::BLOCK_COUNT_RST;
      head        <= '0;
      count       <= '0;
      sweep_on    <= 1'b1;
      sweep_addr  <= '0;
      op_ok       <= 1'b0;
      op_alloc    <= 1'b0;
      op_idx      <= '0;
    end else begin
      if (sweep_on) begin
        sweep_addr <= sweep_addr + IDX_W'(1);
        if (sweep_addr == LAST_ADDR) begin
          sweep_on <= 1'b0;
        end
      end

      unique case (state)
        S_TAKE: begin
          if (accept) begin
            state <= S_CALC;
            if (is_alloc) begin
              op_ok    <= alloc_ok;
              op_alloc <= alloc_ok;
              op_idx   <= alloc_ok ? CNT_W'(head) : '0;
              if (alloc_ok && (CMP_W'(count) < eff)) begin
                count <= count + CNT_W'(1);
              end
            end else begin
              op_ok    <= rel_ok;
              op_alloc <= 1'b0;
              op_idx   <= '0;
              if (rel_ok) begin
                head <= LINK_W'(req.release_index);
                if (count != '0) begin
                  count <= count - CNT_W'(1);
                end
              end
            end
          end
        end
        S_CALC: begin
          if (op_alloc) begin
            head <= mem_rdata;
          end
          if (load) begin
            state <= S_TAKE;
          end
        end
        default: state <= S_TAKE;
      endcase

      if (cfg_we && (cfg_index == fbfl_pkg::REG_BLOCK_SIZE)) begin
        block_size <= cfg_data;
      end
      if (count_write) begin
        block_count <= cfg_data[CNT_W-1:0];
        head        <= '0;
        count       <= '0;
        sweep_on    <= 1'b1;
        sweep_addr  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fbfl_out.sv
`default_nettype none

module fbfl_out (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  fbfl_pkg::result_t                result,
  input  wire logic [fbfl_pkg::SIZE_W-1:0] block_size,
  output logic                             out_free,
  fbfl_rsp_if.source                       rsp
);

  localparam int PROD_W = fbfl_pkg::CNT_W + fbfl_pkg::SIZE_W;

  logic [PROD_W-1:0] off_prod;
  logic [PROD_W-1:0] used_prod;

  assign off_prod  = PROD_W'(result.idx) * PROD_W'(block_size);
  assign used_prod = PROD_W'(result.count) * PROD_W'(block_size);
  assign out_free  = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (result.load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      rsp.ok           <= result.ok;
      rsp.block_index  <= result.idx[fbfl_pkg::BIDX_W-1:0];
      rsp.block_offset <= off_prod[fbfl_pkg::BYTES_W-1:0];
      rsp.used_bytes   <= used_prod[fbfl_pkg::BYTES_W-1:0];
      rsp.allocations  <= result.count;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fbfl_checker.sv
`default_nettype none

module fbfl_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            cfg_we,
  input wire logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic                            rsp_ok,
  input wire logic [fbfl_pkg::BIDX_W-1:0]     rsp_block_index,
  input wire logic [fbfl_pkg::BYTES_W-1:0]    rsp_block_offset
);

  // A pending result is never dropped or withdrawn.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp beat withdrawn before it was taken");

  // Taking a request drops req.ready, so no second request follows it directly.
  a_req_gap: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken in back-to-back cycles");

  // A block count write starts the free-list rebuild.
  a_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == fbfl_pkg::REG_BLOCK_COUNT) |=> !req_ready)
    else $error("request taken right after a block count write");

  // A refused beat carries no block; release beats are not checked here.
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ok |-> (rsp_block_index == '0) && (rsp_block_offset == '0))
    else $error("block reported without a grant");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
  .clk             (clk),
  .rst             (rst),
  .cfg_we          (cfg_we),
  .cfg_index       (cfg_index),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_ok          (rsp.ok),
  .rsp_block_index (rsp.block_index),
  .rsp_block_offset(rsp.block_offset)
);

`default_nettype wire
